// ----- rtl/totp_pkg.sv -----
// ----------------------------------------------------------------------------
// TOTP package
// Shared constants and helpers for the TOTP code generator.
// ----------------------------------------------------------------------------
package totp_pkg;

  localparam int KeyW = 160;

  localparam logic [2:0] CfgKeyHigh   = 3'd0;
  localparam logic [2:0] CfgKeyMiddle = 3'd1;
  localparam logic [2:0] CfgKeyLow    = 3'd2;
  localparam logic [2:0] CfgDigits    = 3'd3;
  localparam logic [2:0] CfgStep      = 3'd4;

  localparam logic [159:0] Sha1Init =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    begin
      if (r < 7'd20) k = 32'h5A827999;
      else if (r < 7'd40) k = 32'h6ED9EBA1;
      else if (r < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
    end
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    begin
      if (r < 7'd20) f = (b & c) | (~b & d);
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
    end
  endfunction

  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] p;
    begin
      unique case (n)
        4'd0: p = 30'd1;
        4'd1: p = 30'd10;
        4'd2: p = 30'd100;
        4'd3: p = 30'd1000;
        4'd4: p = 30'd10000;
        4'd5: p = 30'd100000;
        4'd6: p = 30'd1000000;
        4'd7: p = 30'd10000000;
        4'd8: p = 30'd100000000;
        default: p = 30'd1000000000;
      endcase
      return p;
    end
  endfunction

endpackage

// ----- rtl/totp_sha1_core.sv -----
// ----------------------------------------------------------------------------
// TOTP SHA-1 compression core
// Runs one SHA-1 compression, one round per cycle, over a 16-word window.
// ----------------------------------------------------------------------------
module totp_sha1_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [159:0] h_in,
  input  logic [511:0] blk,
  output logic         done,
  output logic [159:0] h_out
);
  import totp_pkg::*;

  logic [31:0]  w_r [16];
  logic [31:0]  w_nxt [16];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [159:0] h_r;
  logic [6:0]   rnd_r;
  logic         busy_r;
  logic         done_r;
  logic [31:0]  wt, wn, t;

  assign wt = w_r[0];
  assign wn = {w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0]} << 1
              | {31'd0, w_r[13][31] ^ w_r[8][31] ^ w_r[2][31] ^ w_r[0][31]};
  assign t = {a_r[26:0], a_r[31:27]} + round_f(rnd_r, b_r, c_r, d_r) + e_r
             + round_k(rnd_r) + wt;

  always_comb begin
    for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i + 1];
    w_nxt[15] = wn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 7'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= 7'd0;
        h_r    <= h_in;
        {a_r, b_r, c_r, d_r, e_r} <= h_in;
        for (int i = 0; i < 16; i++) w_r[i] <= blk[511 - 32*i -: 32];
      end else if (busy_r) begin
        for (int i = 0; i < 16; i++) w_r[i] <= w_nxt[i];
        e_r <= d_r;
        d_r <= c_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        b_r <= a_r;
        a_r <= t;
        if (rnd_r == 7'd79) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        rnd_r <= rnd_r + 7'd1;
      end
    end
  end

  assign done  = done_r;
  assign h_out = {h_r[159:128] + a_r, h_r[127:96] + b_r, h_r[95:64] + c_r,
                  h_r[63:32] + d_r, h_r[31:0] + e_r};
endmodule

// ----- rtl/totp_code_generator_unit.sv -----
// ----------------------------------------------------------------------------
// TOTP code generator
// Divides the time by the step, runs HMAC-SHA1 and truncates to a password.
// Each beat passes through the divide steps, four compressions in the shared
// SHA-1 core, the modulo steps and the output state. A zero step skips the
// divide steps; an excess digit count goes straight to the output.
// One beat is processed at a time; in_tready is low until the result is taken,
// so a new beat is taken only after the last result has been accepted.
// Reset is synchronous and active low; configuration returns to its defaults.
// ----------------------------------------------------------------------------
module totp_code_generator_unit #(
  parameter int DIGIT_LIMIT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // unix_time[62:0], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // otp_code[26:0], zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import totp_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_H1 = 4'd2, S_H2 = 4'd3,
                         S_H3 = 4'd4, S_H4 = 4'd5, S_MOD = 4'd6, S_OUT = 4'd7,
                         S_W1 = 4'd8, S_W2 = 4'd9, S_W3 = 4'd10, S_W4 = 4'd11;

  logic [63:0]  key_high_r, key_middle_r;
  logic [31:0]  key_low_r, step_r;
  logic [3:0]   digits_r;
  logic [3:0]   state_r;
  logic [62:0]  num_r;
  logic [63:0]  quo_r;
  logic [32:0]  rem_r;
  logic [6:0]   cnt_r;
  logic [159:0] inner_r, ih_r, oh_r, dig_r;
  logic [31:0]  s_r;
  logic [29:0]  mrem_r, mod_r;
  logic [29:0]  mrem_nxt;
  logic [26:0]  code_r;
  logic         sha_start;
  logic [159:0] sha_hin, sha_hout;
  logic [511:0] sha_blk, kpad;
  logic         sha_done;
  logic [32:0]  rsh;
  logic [30:0]  mrsh;
  logic [3:0]   off;
  logic [159:0] shd;
  logic         bad_digits;

  assign kpad = {key_high_r, key_middle_r, key_low_r, 352'd0};
  assign rsh  = {rem_r[31:0], num_r[62]};
  assign mrsh = {mrem_r, s_r[30]};
  assign mrem_nxt = ({1'b0, mrsh} >= {2'b0, mod_r}) ? 30'(mrsh - {1'b0, mod_r})
                                                     : mrsh[29:0];
  assign off  = dig_r[3:0];
  assign shd  = dig_r << {off, 3'b000};
  assign bad_digits = ({28'd0, digits_r} > DIGIT_LIMIT) || (digits_r > 4'd9);

  always_comb begin
    sha_start = 1'b0;
    sha_hin   = Sha1Init;
    sha_blk   = kpad ^ {64{8'h36}};
    unique case (state_r)
      S_H1: sha_start = 1'b1;
      S_H2: begin
        sha_start = 1'b1;
        sha_hin   = ih_r;
        sha_blk   = {quo_r, 8'h80, 376'd0, 64'd576};
      end
      S_H3: begin
        sha_start = 1'b1;
        sha_blk   = kpad ^ {64{8'h5C}};
      end
      S_H4: begin
        sha_start = 1'b1;
        sha_hin   = oh_r;
        sha_blk   = {inner_r, 8'h80, 280'd0, 64'd672};
      end
      default: sha_start = 1'b0;
    endcase
  end

  totp_sha1_core u_sha (
    .clk(clk), .rst_n(rst_n), .start(sha_start), .h_in(sha_hin), .blk(sha_blk),
    .done(sha_done), .h_out(sha_hout)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      key_high_r   <= 64'd0;
      key_middle_r <= 64'd0;
      key_low_r    <= 32'd0;
      digits_r     <= 4'd6;
      step_r       <= 32'd30;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgKeyHigh:   key_high_r   <= cfg_data;
          CfgKeyMiddle: key_middle_r <= cfg_data;
          CfgKeyLow:    key_low_r    <= cfg_data[31:0];
          CfgDigits:    digits_r     <= cfg_data[3:0];
          CfgStep:      step_r       <= cfg_data[31:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          if (bad_digits) begin
            code_r  <= 27'd0;
            state_r <= S_OUT;
          end else begin
            num_r   <= in_tdata[62:0];
            quo_r   <= 64'd0;
            rem_r   <= 33'd0;
            cnt_r   <= 7'd0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (step_r == 32'd0) begin
            quo_r   <= '1;
            state_r <= S_H1;
          end else begin
            num_r <= {num_r[61:0], 1'b0};
            if (rsh >= {1'b0, step_r}) begin
              rem_r <= rsh - {1'b0, step_r};
              quo_r <= {quo_r[62:0], 1'b1};
            end else begin
              rem_r <= rsh;
              quo_r <= {quo_r[62:0], 1'b0};
            end
            cnt_r <= cnt_r + 7'd1;
            if (cnt_r == 7'd62) state_r <= S_H1;
          end
        end
        S_H1: state_r <= S_W1;
        S_W1: if (sha_done) begin ih_r <= sha_hout; state_r <= S_H2; end
        S_H2: state_r <= S_W2;
        S_W2: if (sha_done) begin inner_r <= sha_hout; state_r <= S_H3; end
        S_H3: state_r <= S_W3;
        S_W3: if (sha_done) begin oh_r <= sha_hout; state_r <= S_H4; end
        S_H4: state_r <= S_W4;
        S_W4: if (sha_done) begin dig_r <= sha_hout; state_r <= S_MOD; cnt_r <= 7'd0; end
        S_MOD: begin
          if (cnt_r == 7'd0) begin
            s_r    <= {1'b0, shd[158:128]};
            mrem_r <= 30'd0;
            mod_r  <= pow10(digits_r);
            cnt_r  <= 7'd1;
          end else begin
            s_r    <= {s_r[30:0], 1'b0};
            mrem_r <= mrem_nxt;
            cnt_r  <= cnt_r + 7'd1;
            if (cnt_r == 7'd31) begin
              code_r  <= mrem_nxt[26:0];
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {5'd0, code_r};
endmodule

// ----- tb/totp_code_generator_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TOTP code generator testbench
// Drives time beats through the generator under several key, digit and step
// settings, predicts each password with an independent HMAC-SHA1 model and
// compares every result beat with the oldest predicted password.
// ----------------------------------------------------------------------------
module totp_code_generator_unit_test;
  import totp_pkg::*;

  localparam int DigitLimit = 8;
  localparam int LimitCycles = 4000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  logic [63:0] key_hi_q;
  logic [63:0] key_mid_q;
  logic [31:0] key_lo_q;
  logic [3:0]  digits_q;
  logic [31:0] step_q;

  logic [62:0] pending_times[$];
  logic [26:0] expected_codes[$];
  int          in_gap;
  int          out_gap;
  int          mismatches;
  int          checked;
  int          cycles;

  totp_code_generator_unit #(.DIGIT_LIMIT(DigitLimit)) dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [159:0] sha1_block(input logic [159:0] h,
                                              input logic [511:0] blk);
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    {a, b, c, d, e} = h;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  function automatic logic [26:0] predict_code(input logic [62:0] tm);
    logic [63:0]  counter;
    logic [511:0] padded_key, blk;
    logic [159:0] inner, digest;
    logic [31:0]  window;
    logic [31:0]  modulus;
    int           off;
    if (digits_q > DigitLimit) return '0;
    counter = (step_q == 0) ? '1 : {1'b0, tm} / step_q;
    padded_key = {key_hi_q, key_mid_q, key_lo_q, 352'd0};
    blk = {counter, 8'h80, 376'd0, 64'd576};
    inner = sha1_block(sha1_block(Sha1Init, padded_key ^ {64{8'h36}}), blk);
    blk = {inner, 8'h80, 280'd0, 64'd672};
    digest = sha1_block(sha1_block(Sha1Init, padded_key ^ {64{8'h5C}}), blk);
    off = digest[3:0];
    window = digest[159 - 8 * off -: 32];
    window[31] = 1'b0;
    modulus = 1;
    for (int i = 0; i < digits_q; i++) modulus = modulus * 10;
    return 27'(window % modulus);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgKeyHigh:   key_hi_q  = value;
      CfgKeyMiddle: key_mid_q = value;
      CfgKeyLow:    key_lo_q  = value[31:0];
      CfgDigits:    digits_q  = value[3:0];
      default:      step_q    = value[31:0];
    endcase
  endtask

  task automatic drain;
    while (pending_times.size() != 0 || expected_codes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [62:0] random_time();
    case ($urandom_range(0, 4))
      0: return 63'($urandom_range(0, 200));
      1: return 63'({$urandom, $urandom} >> $urandom_range(0, 62));
      2: return '1 - 63'($urandom_range(0, 100));
      default: return 63'({$urandom, $urandom});
    endcase
  endfunction

  task automatic run_phase(input int count);
    for (int i = 0; i < count; i++) pending_times.push_back(random_time());
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (in_tvalid && !in_tready) begin
    end else begin
      if (in_tvalid) begin
        expected_codes.push_back(predict_code(in_tdata[62:0]));
        void'(pending_times.pop_front());
      end
      if (in_tvalid || in_gap > 0 || pending_times.size() == (in_tvalid ? 1 : 0)) begin
        in_tvalid <= 1'b0;
        if (in_tvalid) in_gap <= $urandom_range(0, 3);
        else if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, pending_times[0]};
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected beat: code %0d", out_tdata);
        end else if (out_tdata !== {5'd0, expected_codes[0]}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d, got %0d", expected_codes[0], out_tdata);
          void'(expected_codes.pop_front());
        end else begin
          void'(expected_codes.pop_front());
        end
        out_tready <= 1'b0;
        out_gap    <= $urandom_range(0, 3);
      end else if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("Timeout after %0d cycles", cycles);
      $display("totp_code_generator_unit verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    key_hi_q = '0;
    key_mid_q = '0;
    key_lo_q = '0;
    digits_q = 4'd6;
    step_q = 32'd30;
    mismatches = 0;
    checked = 0;
    cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats: reset settings, then the special settings.
    pending_times.push_back('0);
    pending_times.push_back('1);
    pending_times.push_back(63'd59);
    drain();
    write_reg(CfgKeyHigh, 64'h3132333435363738);
    write_reg(CfgKeyMiddle, 64'h3930313233343536);
    write_reg(CfgKeyLow, 64'h37383930);
    write_reg(CfgDigits, 64'd8);
    pending_times.push_back(63'd59);
    pending_times.push_back(63'd1111111109);
    pending_times.push_back(63'd2000000000);
    pending_times.push_back(63'd20000000000);
    drain();
    write_reg(CfgStep, 64'd0);
    pending_times.push_back(63'd5);
    pending_times.push_back('1);
    drain();
    write_reg(CfgStep, 64'hFFFFFFFF);
    pending_times.push_back('1);
    pending_times.push_back(63'd12345);
    drain();
    write_reg(CfgStep, 64'd1);
    write_reg(CfgDigits, 64'd0);
    pending_times.push_back(63'd77);
    drain();
    write_reg(CfgDigits, 64'd9);
    pending_times.push_back(63'd77);
    drain();
    write_reg(CfgDigits, 64'd15);
    pending_times.push_back('1);
    drain();
    write_reg(CfgKeyHigh, '1);
    write_reg(CfgKeyMiddle, '1);
    write_reg(CfgKeyLow, 64'hFFFFFFFF);
    write_reg(CfgDigits, 64'd1);
    pending_times.push_back('1);
    pending_times.push_back('0);
    drain();

    for (int phase = 0; phase < 13; phase++) begin
      write_reg(CfgKeyHigh, {$urandom, $urandom});
      write_reg(CfgKeyMiddle, {$urandom, $urandom});
      write_reg(CfgKeyLow, {32'd0, $urandom});
      write_reg(CfgDigits, (phase % 4 == 3) ? 64'($urandom_range(0, 15)) :
                                             64'($urandom_range(6, 8)));
      case (phase % 4)
        0: write_reg(CfgStep, 64'd30);
        1: write_reg(CfgStep, 64'($urandom_range(1, 100)));
        2: write_reg(CfgStep, {32'd0, $urandom});
        default: write_reg(CfgStep, 64'($urandom_range(0, 1)));
      endcase
      run_phase(100);
    end

    $display("Covered %0d result beats over 13 random settings plus directed cases", checked);
    $display("including zero step, all-ones step, zero and excess digit counts");
    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("totp_code_generator_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("totp_code_generator_unit verification failed");
    end
    $finish;
  end
endmodule
